[rtl/pid_tustin_ramp_limit_assert.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property forms for the checks at the end of the controller top level.
// ----------------------------------------------------------------------------
`ifndef PID_TUSTIN_RAMP_LIMIT_ASSERT_SVH
`define PID_TUSTIN_RAMP_LIMIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pid_tustin_ramp_limit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pid_tustin_ramp_limit: next-cycle check failed");

`endif

[rtl/pid_trl_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Register indexes, reset values and shared types of the PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_trl_pkg;

	localparam int COEF_W     = 32;
	localparam int LIMIT_W    = 31;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int ERR_W      = 32;
	localparam int DRIVE_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_COEF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd4;

	localparam logic [COEF_W-1:0]  PROP_GAIN_RST  = 32'd8388608;
	localparam logic [COEF_W-1:0]  INTEG_COEF_RST = 32'd2097;
	localparam logic [COEF_W-1:0]  DERIV_COEF_RST = 32'd0;
	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST  = 31'd393216;
	localparam logic [LIMIT_W-1:0] RAMP_STEP_RST  = 31'd16384;

	// Load strobes for the stages of the multiplier pipeline.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_en_t;

endpackage

`default_nettype wire

[rtl/pid_trl_mul.sv]
// ----------------------------------------------------------------------------
// PID coefficient multiplier
// Three-stage signed times unsigned Q8.24 product, floored and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_trl_mul #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                   clk,
	input  pid_trl_pkg::stage_en_t                 en,
	input  logic [pid_trl_pkg::COEF_W-1:0]         coef,
	input  logic signed [VALUE_WIDTH:0]            opnd,
	output logic signed [VALUE_WIDTH-1:0]          prod
);

	localparam int W  = VALUE_WIDTH;
	localparam int MW = (W + 1 > 25) ? W + 1 : 25;
	localparam int HW = MW - 24;
	localparam int PW = pid_trl_pkg::COEF_W + HW;
	localparam int QW = PW + 1;
	localparam logic [QW-1:0] VLIM = QW'(1) << (W - 1);
	localparam logic signed [W-1:0] VMAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN_W = {1'b1, {(W-1){1'b0}}};

	logic          neg_s2;
	logic [MW-1:0] mag_s2;
	logic          neg_s3;
	logic [55:0]   lo_prod_s3;
	logic [PW-1:0] hi_prod_s3;
	logic signed [W-1:0] prod_s4;

	logic [QW-1:0]       q;
	logic signed [W-1:0] scaled;

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			neg_s2 <= opnd[W];
			mag_s2 <= MW'($unsigned(opnd[W] ? -opnd : opnd));
		end
		if (en.ld_s3) begin
			neg_s3     <= neg_s2;
			lo_prod_s3 <= 56'(coef) * 56'(mag_s2[23:0]);
			hi_prod_s3 <= PW'(coef) * PW'(mag_s2[MW-1:24]);
		end
		if (en.ld_s4) begin
			prod_s4 <= scaled;
		end
	end

	// A negative operand rounds its magnitude up so the result floors.
	always_comb begin
		q = QW'(hi_prod_s3) + QW'(lo_prod_s3[55:24])
			+ QW'(neg_s3 && (lo_prod_s3[23:0] != '0));
		if (neg_s3) begin
			if (q > VLIM) begin
				scaled = VMIN_W;
			end else begin
				scaled = $signed(W'(-q));
			end
		end else begin
			if (q >= VLIM) begin
				scaled = VMAX_W;
			end else begin
				scaled = $signed(W'(q));
			end
		end
	end

	assign prod = prod_s4;

endmodule

`default_nettype wire

[rtl/pid_trl_core.sv]
// ----------------------------------------------------------------------------
// PID accumulate, clamp and ramp stage
// Holds the integral and last output and forms the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_trl_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    ld,
	input  logic signed [VALUE_WIDTH-1:0]           prop,
	input  logic signed [VALUE_WIDTH-1:0]           iinc,
	input  logic signed [VALUE_WIDTH-1:0]           dinc,
	input  logic [pid_trl_pkg::LIMIT_W-1:0]         out_limit,
	input  logic [pid_trl_pkg::LIMIT_W-1:0]         ramp_step,
	output logic signed [pid_trl_pkg::DRIVE_W-1:0]  drive_out,
	output logic                                    integ_clamped,
	output logic                                    out_clamped,
	output logic                                    ramp_limited
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = ((W > 32) ? W : 32) + 2;
	localparam logic signed [CW-1:0] VMAX_C = (CW'(1) << (W - 1)) - CW'(1);
	localparam logic signed [CW-1:0] VMIN_C = ~VMAX_C;
	localparam logic signed [CW-1:0] D_MAX  = (CW'(1) << 31) - CW'(1);
	localparam logic signed [CW-1:0] D_MIN  = ~D_MAX;

	logic signed [W-1:0] integ_acc_q;
	logic signed [W-1:0] last_out_q;
	logic signed [pid_trl_pkg::DRIVE_W-1:0] drive_q;
	logic iclamp_q;
	logic oclamp_q;
	logic rlim_q;

	logic signed [CW-1:0] lim;
	logic signed [CW-1:0] integ;
	logic signed [CW-1:0] psum;
	logic signed [CW-1:0] outv;
	logic signed [CW-1:0] step;
	logic signed [CW-1:0] last_c;
	logic signed [CW-1:0] delta;
	logic signed [CW-1:0] drive_c;
	logic iclamp;
	logic oclamp;
	logic rlim;

	function automatic logic signed [CW-1:0] sat_c(input logic signed [CW-1:0] x);
		logic signed [CW-1:0] r;
		r = x;
		if (x > VMAX_C) begin
			r = VMAX_C;
		end else if (x < VMIN_C) begin
			r = VMIN_C;
		end
		return r;
	endfunction

	always_comb begin
		lim = CW'(out_limit);
		if (lim > VMAX_C) begin
			lim = VMAX_C;
		end

		iclamp = 1'b0;
		integ  = sat_c(CW'(integ_acc_q) + CW'(iinc));
		if (integ > lim) begin
			integ  = lim;
			iclamp = 1'b1;
		end else if (integ < -lim) begin
			integ  = -lim;
			iclamp = 1'b1;
		end

		oclamp = 1'b0;
		psum   = sat_c(CW'(prop) + integ);
		outv   = sat_c(psum + CW'(dinc));
		if (outv > lim) begin
			outv   = lim;
			oclamp = 1'b1;
		end else if (outv < -lim) begin
			outv   = -lim;
			oclamp = 1'b1;
		end

		// The ramp works from the last output and is not clamped to the limit again.
		rlim   = 1'b0;
		step   = CW'(ramp_step);
		last_c = CW'(last_out_q);
		delta  = outv - last_c;
		if (ramp_step != '0) begin
			if (delta > step) begin
				outv = sat_c(last_c + step);
				rlim = 1'b1;
			end else if (delta < -step) begin
				outv = sat_c(last_c - step);
				rlim = 1'b1;
			end
		end

		drive_c = outv;
		if (drive_c > D_MAX) begin
			drive_c = D_MAX;
		end else if (drive_c < D_MIN) begin
			drive_c = D_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_acc_q <= '0;
			last_out_q  <= '0;
		end else if (ld) begin
			integ_acc_q <= W'(integ);
			last_out_q  <= W'(outv);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			drive_q  <= pid_trl_pkg::DRIVE_W'(drive_c);
			iclamp_q <= iclamp;
			oclamp_q <= oclamp;
			rlim_q   <= rlim;
		end
	end

	assign drive_out     = drive_q;
	assign integ_clamped = iclamp_q;
	assign out_clamped   = oclamp_q;
	assign ramp_limited  = rlim_q;

endmodule

`default_nettype wire

[rtl/pid_tustin_ramp_limit.sv]
// ----------------------------------------------------------------------------
// PID controller with Tustin integral, output clamp and ramp limit
// An input passes the error register, the multiplier stages and the output register.
// Throughput: one transaction per cycle unless stalled; the integral and output loop closes in one stage.
// Reset clears integral, last error, last output and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_tustin_ramp_limit_assert.svh"

module pid_tustin_ramp_limit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [pid_trl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pid_trl_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic signed [pid_trl_pkg::ERR_W-1:0]      error_in,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [pid_trl_pkg::DRIVE_W-1:0]    drive_out,
	output logic                                      integ_clamped,
	output logic                                      out_clamped,
	output logic                                      ramp_limited
);

	localparam int W  = VALUE_WIDTH;
	localparam int EW = (W > 32) ? W : 32;
	localparam logic signed [EW-1:0] E_VMAX = (EW'(1) << (W - 1)) - EW'(1);
	localparam logic signed [EW-1:0] E_VMIN = ~E_VMAX;

	logic [pid_trl_pkg::COEF_W-1:0]  prop_gain_q;
	logic [pid_trl_pkg::COEF_W-1:0]  integ_coef_q;
	logic [pid_trl_pkg::COEF_W-1:0]  deriv_coef_q;
	logic [pid_trl_pkg::LIMIT_W-1:0] out_limit_q;
	logic [pid_trl_pkg::LIMIT_W-1:0] ramp_step_q;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_o;

	logic signed [EW-1:0]  err_ext;
	logic signed [EW-1:0]  err_sat;
	logic signed [W-1:0]   e_s1;
	logic signed [W-1:0]   last_err_q;
	logic signed [W:0]     sum_op;
	logic signed [W:0]     diff_op;
	logic signed [W:0]     prop_op;
	logic signed [W-1:0]   prop_v;
	logic signed [W-1:0]   iinc_v;
	logic signed [W-1:0]   dinc_v;
	pid_trl_pkg::stage_en_t en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= pid_trl_pkg::PROP_GAIN_RST;
			integ_coef_q <= pid_trl_pkg::INTEG_COEF_RST;
			deriv_coef_q <= pid_trl_pkg::DERIV_COEF_RST;
			out_limit_q  <= pid_trl_pkg::OUT_LIMIT_RST;
			ramp_step_q  <= pid_trl_pkg::RAMP_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pid_trl_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				pid_trl_pkg::REG_INTEG_COEF: integ_coef_q <= cfg_data;
				pid_trl_pkg::REG_DERIV_COEF: deriv_coef_q <= cfg_data;
				pid_trl_pkg::REG_OUT_LIMIT:  out_limit_q  <= cfg_data[pid_trl_pkg::LIMIT_W-1:0];
				pid_trl_pkg::REG_RAMP_STEP:  ramp_step_q  <= cfg_data[pid_trl_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage takes a new transaction when it is empty or its content moves on.
	assign rdy_o  = !out_valid_q || !out_stall;
	assign rdy_s4 = !v_s4 || rdy_o;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	assign en.ld_s2 = v_s1 && rdy_s2;
	assign en.ld_s3 = v_s2 && rdy_s3;
	assign en.ld_s4 = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			last_err_q  <= '0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_o)  out_valid_q <= v_s4;
			if (en.ld_s2) last_err_q <= e_s1;
		end
	end

	always_comb begin
		err_ext = EW'(error_in);
		err_sat = err_ext;
		if (err_ext > E_VMAX) begin
			err_sat = E_VMAX;
		end else if (err_ext < E_VMIN) begin
			err_sat = E_VMIN;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			e_s1 <= W'(err_sat);
		end
	end

	assign prop_op = (W+1)'(e_s1);
	assign sum_op  = (W+1)'(e_s1) + (W+1)'(last_err_q);
	assign diff_op = (W+1)'(e_s1) - (W+1)'(last_err_q);

	pid_trl_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_prop (
		.clk  (clk),
		.en   (en),
		.coef (prop_gain_q),
		.opnd (prop_op),
		.prod (prop_v)
	);

	pid_trl_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_integ (
		.clk  (clk),
		.en   (en),
		.coef (integ_coef_q),
		.opnd (sum_op),
		.prod (iinc_v)
	);

	pid_trl_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_deriv (
		.clk  (clk),
		.en   (en),
		.coef (deriv_coef_q),
		.opnd (diff_op),
		.prod (dinc_v)
	);

	pid_trl_core #(.VALUE_WIDTH(VALUE_WIDTH)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.ld            (v_s4 && rdy_o),
		.prop          (prop_v),
		.iinc          (iinc_v),
		.dinc          (dinc_v),
		.out_limit     (out_limit_q),
		.ramp_step     (ramp_step_q),
		.drive_out     (drive_out),
		.integ_clamped (integ_clamped),
		.out_clamped   (out_clamped),
		.ramp_limited  (ramp_limited)
	);

	assign out_valid = out_valid_q;

	`PTRL_ASSERT_NOW(a_stall_needs_full_s1, clk, arst_n, in_stall, v_s1)
	`PTRL_ASSERT_NEXT(a_s4_kept_while_blocked, clk, arst_n, v_s4 && out_valid && out_stall, v_s4)
	`PTRL_ASSERT_NOW(a_ramp_flag_needs_step, clk, arst_n, out_valid && ramp_limited, ramp_step_q != '0)

endmodule

`default_nettype wire
